FILE: hdl/cbd_pkg.sv
// Shared types and constants for the counting Bloom discriminator.
package cbd_pkg;

  localparam int NEURON_W   = 6;
  localparam int HASH_W     = 10;
  localparam int RESP_W     = 7;
  localparam int BLEACH_W   = 8;
  localparam int MAX_HASHES = 3;
  localparam int HASH_SEL_W = 2;

  localparam logic [RESP_W-1:0] RESP_MAX = 7'd127;

  localparam logic ACTION_TRAIN = 1'b0;
  localparam logic ACTION_RANK  = 1'b1;

  localparam logic [HASH_SEL_W-1:0] HASH_A = 2'd0;
  localparam logic [HASH_SEL_W-1:0] HASH_B = 2'd1;
  localparam logic [HASH_SEL_W-1:0] HASH_C = 2'd2;

  typedef struct packed {
    logic                action;
    logic [NEURON_W-1:0] neuron_index;
    logic [HASH_W-1:0]   hash_index_a;
    logic [HASH_W-1:0]   hash_index_b;
    logic [HASH_W-1:0]   hash_index_c;
    logic                last_neuron;
  } in_item_t;

  typedef struct packed {
    logic [RESP_W-1:0] response_count;
  } out_item_t;

  typedef logic [BLEACH_W-1:0] bleach_t;

  typedef struct packed {
    logic                  clear_wr;
    logic                  load;
    logic                  rd_issue;
    logic                  update;
    logic                  finish;
    logic [HASH_SEL_W-1:0] hash_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic last;
    logic out_free;
  } ctrl_status_t;

endpackage

FILE: hdl/cbd_chan_if.sv
// Valid/ready channel carrying one payload type.
interface cbd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/cbd_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module cbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

FILE: hdl/cbd_ctrl.sv
// Sequencer: clear sweep, then per item one read/update pair per hash and a finish step.
module cbd_ctrl #(
  parameter int NUM_HASHES = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output cbd_pkg::ctrl_cmd_t    cmd,
  input  cbd_pkg::ctrl_status_t status
);
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t                            state_r, state_nxt;
  logic [cbd_pkg::HASH_SEL_W-1:0]    hash_r, hash_nxt;
  logic                              in_ready_r;

  always_comb begin
    state_nxt    = state_r;
    hash_nxt     = hash_r;
    cmd          = '0;
    cmd.hash_sel = hash_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          hash_nxt  = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (hash_r == cbd_pkg::HASH_SEL_W'(NUM_HASHES - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          hash_nxt  = hash_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_FINISH: begin
        // a marked item waits for room in the output register
        if (!status.last || status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      hash_r     <= '0;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      hash_r     <= hash_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

`ifndef SYNTH
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == ST_IDLE)
    else $error("in_ready high outside idle");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (state_r == ST_READ && hash_r == '0))
    else $error("accepted transaction did not start at first hash");
  a_hash_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(hash_r) < NUM_HASHES)
    else $error("hash select out of range");
  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !cmd.finish) |=> state_r == ST_FINISH)
    else $error("finish step left without delivering result");
`endif
endmodule

FILE: hdl/cbd_datapath.sv
// Item registers, counter memory access, saturating update, minimum, bleach test, count.
module cbd_datapath #(
  parameter int NUM_NEURONS    = 64,
  parameter int FILTER_ENTRIES = 1024,
  parameter int COUNTER_BITS   = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cbd_pkg::in_item_t     in_item,
  input  logic                  cfg_we,
  input  cbd_pkg::bleach_t      cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output cbd_pkg::out_item_t    out_item,
  input  cbd_pkg::ctrl_cmd_t    cmd,
  output cbd_pkg::ctrl_status_t status
);
  localparam int NEUR_EFF = (NUM_NEURONS < (1 << cbd_pkg::NEURON_W)) ?
                            NUM_NEURONS : (1 << cbd_pkg::NEURON_W);
  localparam int DEPTH    = NEUR_EFF * FILTER_ENTRIES;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW       = COUNTER_BITS;
  localparam int CMPW     = (CW > cbd_pkg::BLEACH_W) ? CW : cbd_pkg::BLEACH_W;

  localparam logic [CW-1:0] CNT_MAX = '1;

  cbd_pkg::in_item_t            item_r;
  logic                         neuron_ok_r;
  logic [AW-1:0]                base_r;
  logic [AW-1:0]                addr_r;
  logic                         hit_r;
  logic [CW-1:0]                min_r;
  logic [cbd_pkg::RESP_W-1:0]   resp_r;
  logic [cbd_pkg::RESP_W-1:0]   out_data_r;
  logic                         out_valid_r;
  cbd_pkg::bleach_t             bleach_r;
  logic [AW-1:0]                clr_addr_r;

  logic [cbd_pkg::HASH_W-1:0]   idx_sel;
  logic                         idx_ok;
  logic [AW-1:0]                rd_addr;
  logic [CW-1:0]                rd_data;
  logic [CW-1:0]                cnt_val;
  logic [CW-1:0]                cnt_inc;
  logic                         ram_we;
  logic [AW-1:0]                ram_wr_addr;
  logic [CW-1:0]                ram_wr_data;
  logic                         fire;
  logic [cbd_pkg::RESP_W-1:0]   resp_new;

  always_comb begin
    case (cmd.hash_sel)
      cbd_pkg::HASH_A: idx_sel = item_r.hash_index_a;
      cbd_pkg::HASH_B: idx_sel = item_r.hash_index_b;
      cbd_pkg::HASH_C: idx_sel = item_r.hash_index_c;
      default:         idx_sel = item_r.hash_index_c;
    endcase
  end

  assign idx_ok  = 32'(idx_sel) < FILTER_ENTRIES;
  assign rd_addr = AW'(32'(base_r) + 32'(idx_sel));

  // out-of-range counters read as zero
  assign cnt_val = hit_r ? rd_data : '0;
  assign cnt_inc = (rd_data == CNT_MAX) ? rd_data : rd_data + 1'b1;

  assign ram_we      = cmd.clear_wr ||
                       (cmd.update && hit_r && item_r.action == cbd_pkg::ACTION_TRAIN);
  assign ram_wr_addr = cmd.clear_wr ? clr_addr_r : addr_r;
  assign ram_wr_data = cmd.clear_wr ? '0 : cnt_inc;

  assign fire     = (item_r.action == cbd_pkg::ACTION_RANK) && neuron_ok_r &&
                    (CMPW'(min_r) > CMPW'(bleach_r));
  assign resp_new = (fire && resp_r != cbd_pkg::RESP_MAX) ? resp_r + 1'b1 : resp_r;

  cbd_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r      <= in_item;
      neuron_ok_r <= 32'(in_item.neuron_index) < NUM_NEURONS;
      base_r      <= AW'(32'(in_item.neuron_index) * 32'(FILTER_ENTRIES));
      min_r       <= '1;
    end
    if (cmd.rd_issue) begin
      addr_r <= rd_addr;
      hit_r  <= neuron_ok_r && idx_ok;
    end
    if (cmd.update && cnt_val < min_r) begin
      min_r <= cnt_val;
    end
    if (cmd.finish && item_r.last_neuron) begin
      out_data_r <= resp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_r      <= '0;
      out_valid_r <= 1'b0;
      bleach_r    <= '0;
      clr_addr_r  <= '0;
    end else begin
      if (cfg_we) begin
        bleach_r <= cfg_data;
      end
      if (cmd.clear_wr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.finish) begin
        resp_r <= item_r.last_neuron ? '0 : resp_new;
      end
      if (cmd.finish && item_r.last_neuron) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.clear_last = (clr_addr_r == AW'(DEPTH - 1));
  assign status.last       = item_r.last_neuron;
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid               = out_valid_r;
  assign out_item.response_count = out_data_r;
endmodule

FILE: hdl/counting_bloom_discriminator_top.sv
// Counting Bloom filter discriminator: per-neuron counter tables, train and bleached rank.
//
// Channels: in_chan takes one item (action, neuron, up to three hash indices, last mark),
// out_chan gives the fired-neuron count of a sample, cfg_chan writes the bleach level
// and is always ready. Transactions complete when valid and ready are both high.
// Per item the sequencer runs one read/update pair for each hash on the single read
// port of the counter memory, then a finish step; the next item is accepted only after
// that finish step. A marked item's result is written to the output register there.
// After reset a clearing pass writes zero to every counter, min(NUM_NEURONS,64) *
// FILTER_ENTRIES of them (65536 by default); in_chan.ready stays low during it.
// The result sits in an output register: later items are still taken while it waits,
// and only the next marked item stalls at its finish step until the register is taken.
module counting_bloom_discriminator_top #(
  parameter int NUM_NEURONS    = 64,
  parameter int FILTER_ENTRIES = 1024,
  parameter int NUM_HASHES     = 3,
  parameter int COUNTER_BITS   = 8
) (
  input logic      clk,
  input logic      rst_n,
  cbd_chan_if.sink   in_chan,
  cbd_chan_if.source out_chan,
  cbd_chan_if.sink   cfg_chan
);
  cbd_pkg::ctrl_cmd_t    cmd;
  cbd_pkg::ctrl_status_t status;
  cbd_pkg::out_item_t    out_item;
  logic                  out_valid;

  assign cfg_chan.ready = 1'b1;

  cbd_ctrl #(
    .NUM_HASHES (NUM_HASHES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .status   (status)
  );

  cbd_datapath #(
    .NUM_NEURONS    (NUM_NEURONS),
    .FILTER_ENTRIES (FILTER_ENTRIES),
    .COUNTER_BITS   (COUNTER_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_chan.payload),
    .cfg_we    (cfg_chan.valid),
    .cfg_data  (cfg_chan.payload),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .status    (status)
  );

  assign out_chan.valid   = out_valid;
  assign out_chan.payload = out_item;
endmodule
